// ----- rtl/multilevel_priority_ready_queue_assert.svh -----
// Assertion macros shared by the queue checker.
`ifndef MULTILEVEL_PRIORITY_READY_QUEUE_ASSERT_SVH
`define MULTILEVEL_PRIORITY_READY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mpq_pkg.sv -----
// Types, codes and constants of the multilevel priority ready queue.
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int ENTRIES   = 64;
  localparam int LEVELS    = 3;
  localparam int ID_W      = $clog2(ENTRIES);
  localparam int LV_W      = 2;
  localparam int PERIOD_W  = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [PERIOD_W-1:0] RESET_PERIOD_INIT  = PERIOD_W'(5000000);
  localparam logic [LV_W-1:0]     DEFAULT_LEVEL_INIT = LV_W'(1);
  localparam logic [LV_W-1:0]     LAST_LEVEL         = LV_W'(LEVELS - 1);

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_SETPRI = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_EMPTY      = 3'd1,
    STAT_NOT_QUEUED = 3'd2,
    STAT_ALREADY    = 3'd3,
    STAT_BAD_LEVEL  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_PERIOD  = 1'b0,
    CFG_DEFAULT_LEVEL = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    req_t            req_type;
    logic [ID_W-1:0] entry_id;
    logic [LV_W-1:0] level;
  } in_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] out_id;
    logic            reset_fired;
  } out_t;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_INSERT  = 3'd1,
    CELL_SHIFT   = 3'd2,
    CELL_MARK    = 3'd3,
    CELL_BUBBLE  = 3'd4,
    CELL_ROTATE  = 3'd5,
    CELL_RELABEL = 3'd6
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] id;
    logic [LV_W-1:0] lv;
  } cmd_t;

  // Contents of one cell: one queued entry and its level.
  typedef struct packed {
    logic            valid;
    logic            hole;
    logic [ID_W-1:0] id;
    logic [LV_W-1:0] level;
  } cell_t;

  // Tie-off left of the first cell: reads as an occupied, most urgent slot.
  localparam cell_t LEFT_EDGE  = '{valid: 1'b1, hole: 1'b0, id: '0, level: '0};
  // Tie-off right of the last cell: reads as an empty slot.
  localparam cell_t RIGHT_EDGE = '{valid: 1'b0, hole: 1'b0, id: '0, level: '0};

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_BUBBLE = 2'd1,
    S_ROTATE = 2'd2
  } state_t;

endpackage

// ----- rtl/mpq_cell.sv -----
// One slot of the sorted entry row: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module mpq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  mpq_pkg::cmd_t  cmd,
  input  mpq_pkg::cell_t left,
  input  mpq_pkg::cell_t right,
  input  mpq_pkg::cell_t head,
  output mpq_pkg::cell_t slot
);
  import mpq_pkg::*;

  logic            valid_r, valid_nxt;
  logic            hole_r, hole_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [LV_W-1:0] level_r, level_nxt;
  cell_t           cur, take;
  logic            c_self, c_left, c_right;

  assign cur  = '{valid: valid_r, hole: hole_r, id: id_r, level: level_r};
  assign slot = cur;

  // Slot lies past the insertion point of level cmd.lv (row is sorted by level)
  assign c_self  = !cur.valid   || (cur.level   > cmd.lv);
  assign c_left  = !left.valid  || (left.level  > cmd.lv);
  assign c_right = !right.valid || (right.level > cmd.lv);

  // Pick the next contents of this slot
  always_comb begin
    take = cur;
    unique case (cmd.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (c_left) begin
          take      = left;
          take.hole = 1'b0;
        end else if (c_self) begin
          take = '{valid: 1'b1, hole: 1'b0, id: cmd.id, level: cmd.lv};
        end
      end
      CELL_SHIFT: begin
        take = right;
      end
      CELL_MARK: begin
        if (cur.valid && (cur.id == cmd.id)) begin
          take.hole = 1'b1;
        end
      end
      CELL_BUBBLE: begin
        // Move the hole one slot toward the tail, closing it at the end
        if (cur.hole) begin
          if (right.valid) begin
            take      = right;
            take.hole = 1'b0;
          end else begin
            take.valid = 1'b0;
            take.hole  = 1'b0;
          end
        end else if (left.hole && cur.valid) begin
          take.hole = 1'b1;
        end
      end
      CELL_ROTATE: begin
        // Rotate the head entry behind the last entry of the default level
        if (!c_right) begin
          take = right;
        end else if (!c_self) begin
          take       = head;
          take.level = cmd.lv;
        end
      end
      CELL_RELABEL: begin
        if (cur.valid) begin
          take.level = cmd.lv;
        end
      end
      default: begin
      end
    endcase
  end

  assign valid_nxt = take.valid;
  assign hole_nxt  = take.hole;
  assign id_nxt    = take.id;
  assign level_nxt = take.level;

  // Occupancy flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hole_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hole_r  <= hole_nxt;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    level_r <= level_nxt;
  end

endmodule

// ----- rtl/mpq_row.sv -----
// Row of entry cells, sorted by level and by age within each level.
`timescale 1ns / 1ps

module mpq_row (
  input  logic           clk,
  input  logic           rst_n,
  input  mpq_pkg::cmd_t  cmd,
  output mpq_pkg::cell_t head,
  output logic           hole_any
);
  import mpq_pkg::*;

  cell_t              cells    [ENTRIES];
  cell_t              left_in  [ENTRIES];
  cell_t              right_in [ENTRIES];
  logic [ENTRIES-1:0] hole_vec;

  // Chain the cells, tying off both ends
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = LEFT_EDGE;
    end else begin : g_mid_l
      assign left_in[i] = cells[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign right_in[i] = RIGHT_EDGE;
    end else begin : g_mid_r
      assign right_in[i] = cells[i+1];
    end

    mpq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (left_in[i]),
      .right (right_in[i]),
      .head  (cells[0]),
      .slot  (cells[i])
    );

    assign hole_vec[i] = cells[i].hole;
  end

  assign head     = cells[0];
  assign hole_any = |hole_vec;

endmodule

// ----- rtl/multilevel_priority_ready_queue.sv -----
// Top level of the multilevel priority ready queue.
//
// Usage: requests enter on in_valid/in_stall with in_data (enqueue, dequeue,
// set priority, tick); each request gives exactly one result on
// out_valid/out_stall with out_data. Registers reset_period and
// default_level are written over cfg_valid/cfg_ready while the queue is idle.
// Enqueue, dequeue and a tick that does not fire are done at once: the result
// is registered at the accepting edge, and a new request may follow in the
// next cycle. Set priority marks the moved entry as a hole, which walks one
// cell per cycle down the row of entry cells and closes past the last entry;
// the entry is then appended at the tail of its new level. A tick that fires
// rotates the entries in levels more urgent than the default level one per
// cycle behind the default level, then relabels every entry.
// Reset empties all levels, sets the countdown and reset_period to 5000000
// and default_level to 1; no clearing pass is needed.
// While the receiver stalls, the result is held in the output register and
// one more result is buffered; after that, in_stall stays high.
`timescale 1ns / 1ps

module multilevel_priority_ready_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mpq_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mpq_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpq_pkg::PERIOD_W-1:0]     cfg_data
);
  import mpq_pkg::*;

  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [LV_W-1:0]     default_level_r;
  logic [PERIOD_W-1:0] countdown_r, countdown_nxt;
  logic [ENTRIES-1:0]  queued_r, queued_nxt;
  logic [ID_W-1:0]     id_r;
  logic [LV_W-1:0]     lv_r;
  logic                out_valid_r, hold_valid_r;
  out_t                out_data_r, hold_data_r;

  cmd_t                cmd;
  cell_t               head;
  logic                hole_any;
  logic                res_valid;
  out_t                res_data;

  logic                in_acc, cfg_acc, out_free;
  logic                bad_lv, id_queued, count_zero, rotate_more;
  logic [LV_W-1:0]     dl_eff;

  assign in_stall  = (state_r != S_IDLE) || hold_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;

  assign bad_lv      = in_data.level > LAST_LEVEL;
  assign id_queued   = queued_r[in_data.entry_id];
  assign count_zero  = (countdown_r == '0);
  assign dl_eff      = (default_level_r > LAST_LEVEL) ? LAST_LEVEL : default_level_r;
  assign rotate_more = head.valid && (head.level < dl_eff);

  mpq_row u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .head     (head),
    .hole_any (hole_any)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_data.req_type == REQ_SETPRI) && !bad_lv && id_queued) begin
            state_nxt = S_BUBBLE;
          end else if ((in_data.req_type == REQ_TICK) && count_zero) begin
            state_nxt = S_ROTATE;
          end
        end
      end
      S_BUBBLE: begin
        if (!hole_any) begin
          state_nxt = S_IDLE;
        end
      end
      S_ROTATE: begin
        if (!rotate_more) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Row commands, results and bookkeeping
  always_comb begin
    cmd           = '{op: CELL_HOLD, id: '0, lv: '0};
    res_valid     = 1'b0;
    res_data      = '{status: STAT_OK, out_id: '0, reset_fired: 1'b0};
    countdown_nxt = countdown_r;
    queued_nxt    = queued_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.req_type)
            REQ_ENQ: begin
              res_valid = 1'b1;
              if (bad_lv) begin
                res_data.status = STAT_BAD_LEVEL;
              end else if (id_queued) begin
                res_data.status = STAT_ALREADY;
              end else begin
                cmd = '{op: CELL_INSERT, id: in_data.entry_id, lv: in_data.level};
                queued_nxt[in_data.entry_id] = 1'b1;
              end
            end
            REQ_DEQ: begin
              res_valid = 1'b1;
              if (head.valid) begin
                cmd.op                = CELL_SHIFT;
                queued_nxt[head.id]   = 1'b0;
                res_data.out_id       = head.id;
              end else begin
                res_data.status = STAT_EMPTY;
              end
            end
            REQ_SETPRI: begin
              if (bad_lv) begin
                res_valid       = 1'b1;
                res_data.status = STAT_BAD_LEVEL;
              end else if (!id_queued) begin
                res_valid       = 1'b1;
                res_data.status = STAT_NOT_QUEUED;
              end else begin
                cmd = '{op: CELL_MARK, id: in_data.entry_id, lv: in_data.level};
              end
            end
            REQ_TICK: begin
              if (count_zero) begin
                countdown_nxt = period_r;
              end else begin
                countdown_nxt = countdown_r - PERIOD_W'(1);
                res_valid     = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_BUBBLE: begin
        // Close the gap, then append at the tail of the new level
        if (hole_any) begin
          cmd.op = CELL_BUBBLE;
        end else begin
          cmd       = '{op: CELL_INSERT, id: id_r, lv: lv_r};
          res_valid = 1'b1;
        end
      end
      S_ROTATE: begin
        // Move urgent entries behind the default level, then relabel all
        if (rotate_more) begin
          cmd = '{op: CELL_ROTATE, id: '0, lv: dl_eff};
        end else begin
          cmd                  = '{op: CELL_RELABEL, id: '0, lv: dl_eff};
          res_valid            = 1'b1;
          res_data.reset_fired = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      period_r        <= RESET_PERIOD_INIT;
      default_level_r <= DEFAULT_LEVEL_INIT;
      countdown_r     <= RESET_PERIOD_INIT;
      queued_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      countdown_r <= countdown_nxt;
      queued_r    <= queued_nxt;
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_RESET_PERIOD:  period_r        <= cfg_data;
          CFG_DEFAULT_LEVEL: default_level_r <= cfg_data[LV_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Hold the request operands for multi-cycle work
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r <= in_data.entry_id;
      lv_r <= in_data.level;
    end
  end

  // Output register plus one buffered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= hold_valid_r || res_valid;
      hold_valid_r <= 1'b0;
    end else if (res_valid) begin
      hold_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid_r) begin
        out_data_r <= hold_data_r;
      end else if (res_valid) begin
        out_data_r <= res_data;
      end
    end else if (res_valid) begin
      hold_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/mpq_checker.sv -----
// Port-level checks of the multilevel priority ready queue, bound to the top level.
`timescale 1ns / 1ps
`include "multilevel_priority_ready_queue_assert.svh"

module mpq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input mpq_pkg::in_t                  in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input mpq_pkg::out_t                 out_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [mpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [mpq_pkg::PERIOD_W-1:0]  cfg_data
);
  import mpq_pkg::*;

  // A stalled request stays put
  `MPQ_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall,
                   in_valid && $stable(in_data), "request changed while stalled")

  // A pending register write stays put
  `MPQ_ASSERT_NEXT(a_cfg_hold, clk, rst_n, cfg_valid && !cfg_ready,
                   cfg_valid && $stable(cfg_index) && $stable(cfg_data),
                   "register write changed while waiting")

  // A stalled result stays put
  `MPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_data), "result changed while stalled")

  // A fired reset is only reported by a successful tick
  `MPQ_ASSERT_SAME(a_fired_ok, clk, rst_n, out_valid && out_data.reset_fired,
                   (out_data.status == STAT_OK) && (out_data.out_id == '0),
                   "reset_fired with bad status or id")

  // Failed requests carry neither an id nor a reset flag
  `MPQ_ASSERT_SAME(a_fail_clean, clk, rst_n, out_valid && (out_data.status != STAT_OK),
                   (out_data.out_id == '0) && !out_data.reset_fired,
                   "failed request returned data")

endmodule

bind multilevel_priority_ready_queue mpq_checker u_mpq_checker (.*);

// ----- tb/sv/ready_queue_checker.sv -----
// Checker for the multilevel priority ready queue: predicts and compares every result.
`timescale 1ns / 1ps

module ready_queue_checker
  import mpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_t                  out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PERIOD_W-1:0]   cfg_data,
  output int                    fail_count,
  output int                    outstanding,
  output int                    results_seen,
  output int                    fires_seen
);

  localparam int REPORT_CAP = 10;

  // Shadow copy of the queue: per-level linked lists of entry ids
  bit [ID_W-1:0]     succ_id   [ENTRIES];
  bit [ID_W-1:0]     head_id   [LEVELS];
  bit [ID_W-1:0]     tail_id   [LEVELS];
  bit                lv_filled [LEVELS];
  bit [LV_W-1:0]     lv_of     [ENTRIES];
  bit                queued    [ENTRIES];
  bit [PERIOD_W-1:0] ticks_left;
  bit [PERIOD_W-1:0] reload_period;
  bit [LV_W-1:0]     home_level;

  out_t outcome_q[$];
  int   fails;
  int   n_results;
  int   n_fires;

  // Link an entry at the tail of a level
  task automatic append_to_level(input int id, input int lv);
    succ_id[id] = '0;
    if (lv_filled[lv]) begin
      succ_id[tail_id[lv]] = ID_W'(id);
    end else begin
      head_id[lv] = ID_W'(id);
    end
    tail_id[lv]   = ID_W'(id);
    lv_filled[lv] = 1'b1;
    lv_of[id]     = LV_W'(lv);
    queued[id]    = 1'b1;
  endtask

  // Apply one request to the shadow queue and return the result it gives
  task automatic predict_outcome(input in_t rq, output out_t res);
    int  id;
    int  lv;
    int  l;
    int  i;
    int  prv;
    int  dl;
    bit  done;
    res.status      = STAT_OK;
    res.out_id      = '0;
    res.reset_fired = 1'b0;
    id   = int'(rq.entry_id);
    lv   = int'(rq.level);
    done = 1'b0;
    case (rq.req_type)
      REQ_ENQ: begin
        if (lv >= LEVELS) res.status = STAT_BAD_LEVEL;
        else if (queued[id]) res.status = STAT_ALREADY;
        else append_to_level(id, lv);
      end
      REQ_DEQ: begin
        // take the oldest entry of the most urgent filled level
        res.status = STAT_EMPTY;
        for (l = 0; l < LEVELS; l++) begin
          if (!done && lv_filled[l]) begin
            prv = int'(head_id[l]);
            if (tail_id[l] == prv) lv_filled[l] = 1'b0;
            else head_id[l] = succ_id[prv];
            queued[prv] = 1'b0;
            res.out_id  = ID_W'(prv);
            res.status  = STAT_OK;
            done        = 1'b1;
          end
        end
      end
      REQ_SETPRI: begin
        if (lv >= LEVELS) begin
          res.status = STAT_BAD_LEVEL;
        end else if (!queued[id]) begin
          res.status = STAT_NOT_QUEUED;
        end else begin
          // unlink from the current level, then append to the new one
          l = int'(lv_of[id]);
          queued[id] = 1'b0;
          if (lv_filled[l]) begin
            if (head_id[l] == id) begin
              if (tail_id[l] == id) lv_filled[l] = 1'b0;
              else head_id[l] = succ_id[id];
            end else begin
              prv = int'(head_id[l]);
              for (i = 0; i < ENTRIES && !done; i++) begin
                if (prv == tail_id[l]) begin
                  done = 1'b1;
                end else if (succ_id[prv] == id) begin
                  succ_id[prv] = succ_id[id];
                  if (tail_id[l] == id) tail_id[l] = ID_W'(prv);
                  done = 1'b1;
                end else begin
                  prv = int'(succ_id[prv]);
                end
              end
            end
          end
          append_to_level(id, lv);
        end
      end
      default: begin
        if (ticks_left != '0) begin
          ticks_left = ticks_left - 1'b1;
        end else begin
          // periodic reset: splice every other level behind the default level
          ticks_left      = reload_period;
          res.reset_fired = 1'b1;
          dl = (home_level >= LEVELS) ? LEVELS - 1 : int'(home_level);
          for (l = 0; l < LEVELS; l++) begin
            if (l != dl && lv_filled[l]) begin
              if (lv_filled[dl]) succ_id[tail_id[dl]] = head_id[l];
              else head_id[dl] = head_id[l];
              tail_id[dl]   = tail_id[l];
              lv_filled[dl] = 1'b1;
              lv_filled[l]  = 1'b0;
            end
          end
          for (i = 0; i < ENTRIES; i++) begin
            if (queued[i]) lv_of[i] = LV_W'(dl);
          end
        end
      end
    endcase
  endtask

  // Watch the three channels at each edge
  always @(posedge clk) begin : watch
    out_t want;
    out_t res;
    int   l;
    int   i;
    if (!rst_n) begin
      for (l = 0; l < LEVELS; l++) lv_filled[l] = 1'b0;
      for (i = 0; i < ENTRIES; i++) queued[i] = 1'b0;
      ticks_left    = RESET_PERIOD_INIT;
      reload_period = RESET_PERIOD_INIT;
      home_level    = DEFAULT_LEVEL_INIT;
      outcome_q.delete();
      fails     = 0;
      n_results = 0;
      n_fires   = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RESET_PERIOD:  reload_period = cfg_data;
          CFG_DEFAULT_LEVEL: home_level    = cfg_data[LV_W-1:0];
          default: ;
        endcase
      end
      // compare a result against the oldest prediction
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_data.reset_fired === 1'b1) n_fires++;
        if (outcome_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_CAP)
            $display("unexpected result: status %0d id %0d fired %0d",
                     out_data.status, out_data.out_id, out_data.reset_fired);
        end else begin
          want = outcome_q.pop_front();
          if (out_data.status !== want.status || out_data.out_id !== want.out_id ||
              out_data.reset_fired !== want.reset_fired) begin
            fails++;
            if (fails <= REPORT_CAP)
              $display("mismatch (status/id/fired): expected %0d/%0d/%0d got %0d/%0d/%0d",
                       want.status, want.out_id, want.reset_fired,
                       out_data.status, out_data.out_id, out_data.reset_fired);
          end
        end
      end
      // predict the result of an accepted request
      if (in_valid && !in_stall) begin
        predict_outcome(in_data, res);
        outcome_q.push_back(res);
      end
    end
    fail_count   <= fails;
    outstanding  <= outcome_q.size();
    results_seen <= n_results;
    fires_seen   <= n_fires;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the ready queue testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import mpq_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_LEN    = 300;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 250;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_t                  in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PERIOD_W-1:0]  cfg_data  = '0;
  logic                 in_stall;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_ready;

  int fail_count;
  int outstanding;
  int results_seen;
  int fires_seen;
  int quiet_cycles = 0;
  int hold_tokens  = 0;
  bit steady       = 1'b0;
  int sent_by_kind [4];
  int settings_used = 0;

  always #5 clk = ~clk;

  multilevel_priority_ready_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ready_queue_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .fires_seen   (fires_seen)
  );

  // Abort when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int served;
    int k;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_tokens != served) begin
        served++;
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_LEN; k++) @(posedge clk);
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 20);
      end
    end
  end

  function automatic in_t make_req(req_t kind, int id, int lv);
    in_t r;
    r.req_type = kind;
    r.entry_id = ID_W'(id);
    r.level    = LV_W'(lv);
    return r;
  endfunction

  // Random request; enq_pct shifts the mix between filling and draining
  function automatic in_t random_req(int enq_pct);
    in_t r;
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick < enq_pct) r.req_type = REQ_ENQ;
    else if (pick < 60) r.req_type = REQ_DEQ;
    else if (pick < 85) r.req_type = REQ_SETPRI;
    else r.req_type = REQ_TICK;
    // favor a small id window so repeats and moves of queued entries are common
    if ($urandom_range(0, 1) == 1) r.entry_id = ID_W'($urandom_range(0, 15));
    else r.entry_id = ID_W'($urandom_range(0, ENTRIES - 1));
    if ($urandom_range(0, 99) < 8) r.level = LV_W'(3);
    else r.level = LV_W'($urandom_range(0, LEVELS - 1));
    return r;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_req(input in_t r, input bit may_idle);
    if (may_idle && !steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    sent_by_kind[r.req_type]++;
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write both registers while the queue is idle
  task automatic write_settings(input logic [PERIOD_W-1:0] period, input int dflt);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_RESET_PERIOD;
    cfg_data  <= period;
    do @(posedge clk); while (!cfg_ready);
    // upper bits of the level write are don't-care
    cfg_index <= CFG_DEFAULT_LEVEL;
    cfg_data  <= {(PERIOD_W - LV_W)'($urandom), LV_W'(dflt)};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [PERIOD_W-1:0] periods [PHASES];
    int                  dflts   [PHASES];
    int                  p;
    int                  k;
    periods = '{24'd2, 24'd0, 24'd7, 24'd1, 24'hFFFFFF};
    dflts   = '{2, 0, 3, 1, 2};
    for (k = 0; k < 4; k++) sent_by_kind[k] = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty dequeue, bad levels, unqueued and same-level moves
    send_req(make_req(REQ_DEQ, 0, 0), 1);
    send_req(make_req(REQ_ENQ, 0, 3), 1);
    send_req(make_req(REQ_SETPRI, 5, 3), 1);
    send_req(make_req(REQ_SETPRI, 5, 1), 1);
    send_req(make_req(REQ_ENQ, 63, 2), 1);
    send_req(make_req(REQ_ENQ, 0, 0), 1);
    send_req(make_req(REQ_ENQ, 42, 1), 1);
    send_req(make_req(REQ_ENQ, 21, 0), 1);
    send_req(make_req(REQ_ENQ, 7, 2), 1);
    send_req(make_req(REQ_ENQ, 0, 1), 1);
    send_req(make_req(REQ_ENQ, 7, 3), 1);
    send_req(make_req(REQ_SETPRI, 42, 1), 1);
    send_req(make_req(REQ_SETPRI, 0, 0), 1);
    send_req(make_req(REQ_SETPRI, 63, 0), 1);
    send_req(make_req(REQ_ENQ, 12, 1), 1);
    send_req(make_req(REQ_SETPRI, 0, 2), 1);
    send_req(make_req(REQ_TICK, 0, 0), 1);
    send_req(make_req(REQ_ENQ, 33, 2), 1);
    drain();

    // Rewrite the registers; the running countdown is untouched
    write_settings(24'd3, 1);

    // Empty the queue to check the dequeue order
    for (k = 0; k < 8; k++) send_req(make_req(REQ_DEQ, 63, 3), 1);

    // Random phases over several register settings
    for (p = 0; p < PHASES; p++) begin
      drain();
      write_settings(periods[p], dflts[p]);
      steady <= (p == 2);
      if (p == 1 || p == 3) hold_tokens <= hold_tokens + 1;
      for (k = 0; k < PHASE_ITEMS; k++) send_req(random_req((p % 2 == 0) ? 45 : 25), 1);
    end
    drain();
    repeat (20) @(posedge clk);

    $display("requests: %0d enqueue, %0d dequeue, %0d set priority, %0d tick",
             sent_by_kind[REQ_ENQ], sent_by_kind[REQ_DEQ], sent_by_kind[REQ_SETPRI],
             sent_by_kind[REQ_TICK]);
    $display("%0d results checked, %0d periodic resets, %0d register settings, %0d failures",
             results_seen, fires_seen, settings_used, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
